### rtl/slri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slri_pkg: shared types and constants of the sorted list core
// Command codes, field widths, and the command/status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package slri_pkg;

	// default list depth
	localparam int CAPACITY_DEF = 32;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;

	// command codes carried in s_tuser
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture value, build insert mask, clear result
		logic spread;   // one doubling step of the insert mask
		logic shift;    // move cells up and drop the value in
		logic append;   // write value at the fill position
		logic rsel;     // pick the last cell, decrement fill
		logic rread;    // read the picked cell into the result
		logic publish;  // load the output word
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic spread_last;
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/slri_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slri_ctrl: command sequencer
// Accepts one word, walks the datapath through the steps of that command
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module slri_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic [slri_pkg::CMD_W-1:0]  s_cmd,
	output logic                             s_tready,
	input  wire logic                        m_tready,
	output logic                             m_tvalid,
	input  wire slri_pkg::dp_stat_t          stat,
	output slri_pkg::dp_cmd_t                cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SPREAD = 7'b0000010,
		ST_SHIFT  = 7'b0000100,
		ST_APPEND = 7'b0001000,
		ST_RSEL   = 7'b0010000,
		ST_RREAD  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.load    = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (s_cmd == slri_pkg::CMD_INSERT) begin
						state_d = stat.full ? ST_DONE : ST_SPREAD;
					end else if (s_cmd == slri_pkg::CMD_APPEND) begin
						state_d = stat.full ? ST_DONE : ST_APPEND;
					end else if (s_cmd == slri_pkg::CMD_REMOVE) begin
						state_d = stat.empty ? ST_DONE : ST_RSEL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SPREAD: begin
				cmd.spread = 1'b1;
				if (stat.spread_last) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = ST_DONE;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_DONE;
			end
			ST_RSEL: begin
				cmd.rsel = 1'b1;
				state_d  = ST_RREAD;
			end
			ST_RREAD: begin
				cmd.rread = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second word taken while a command is in progress");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("output valid raised outside the done step");
`endif

endmodule
`default_nettype wire

### rtl/slri_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slri_dp: list cells and result register
// A row of cells with a compare each; insert builds a position mask,
// widens it by doubling, then shifts the upper cells in one step.
// ----------------------------------------------------------------------------
module slri_dp #(
	parameter int CAPACITY = slri_pkg::CAPACITY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire slri_pkg::dp_cmd_t                 cmd,
	output slri_pkg::dp_stat_t                     stat,
	input  wire logic signed [slri_pkg::VALUE_W-1:0] s_value,
	output logic                                   out_ok,
	output logic signed [slri_pkg::VALUE_W-1:0]    out_removed,
	output logic [slri_pkg::COUNT_W-1:0]           out_count
);

	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int LOG_STEPS = $clog2(CAPACITY);
	localparam int STEP_W    = $clog2(LOG_STEPS + 1);

	logic signed [slri_pkg::VALUE_W-1:0] entry_q [CAPACITY];
	logic signed [slri_pkg::VALUE_W-1:0] val_q;
	logic signed [slri_pkg::VALUE_W-1:0] rd_word;
	logic signed [slri_pkg::VALUE_W-1:0] removed_q;
	logic [CAPACITY-1:0] mask_q;
	logic [CAPACITY-1:0] mask_up;
	logic [CAPACITY-1:0] sel_q;
	logic [CNT_W-1:0]    count_q;
	logic [STEP_W-1:0]   step_q;
	logic                ok_q;

	assign stat.full        = (count_q == CNT_W'(CAPACITY));
	assign stat.empty       = (count_q == '0);
	assign stat.spread_last = (step_q == STEP_W'(LOG_STEPS - 1));

	// insert mask moved up by the current doubling distance
	assign mask_up = mask_q << (1 << step_q);

	// per-cell storage, compare and select
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.load) begin
				mask_q[i] <= ((CNT_W'(i) < count_q) && (entry_q[i] > s_value))
				             || (CNT_W'(i) == count_q);
			end else if (cmd.spread) begin
				mask_q[i] <= mask_q[i] | mask_up[i];
			end
			if (cmd.rsel) sel_q[i] <= (CNT_W'(i) == count_q - 1'b1);
			if (cmd.shift && mask_q[i]) begin
				if (i == 0) entry_q[i] <= val_q;
				else entry_q[i] <= mask_q[(i == 0) ? 0 : i - 1] ?
				                   entry_q[(i == 0) ? 0 : i - 1] : val_q;
			end else if (cmd.append && (CNT_W'(i) == count_q)) begin
				entry_q[i] <= val_q;
			end
		end
	end

	// one-hot read of the last cell
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | (sel_q[i] ? entry_q[i] : '0);
		end
	end

	// value, step counter, result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q     <= s_value;
			ok_q      <= 1'b0;
			removed_q <= '0;
			step_q    <= '0;
		end else begin
			if (cmd.spread) step_q <= step_q + 1'b1;
			if (cmd.shift || cmd.append) ok_q <= 1'b1;
			if (cmd.rread) begin
				ok_q      <= 1'b1;
				removed_q <= rd_word;
			end
		end
		if (cmd.publish) begin
			out_ok      <= ok_q;
			out_removed <= removed_q;
			out_count   <= slri_pkg::COUNT_W'(count_q);
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.shift || cmd.append) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.rsel) begin
			count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");
	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.spread || cmd.shift || cmd.append) |-> !stat.full)
		else $error("write step issued on a full list");
	a_remove_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsel |-> !stat.empty)
		else $error("remove step issued on an empty list");
`endif

endmodule
`default_nettype wire

### rtl/sorted_list_insert_remove_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core: sorted list with insert, append, remove
// States: insert SPREAD, SHIFT, DONE; append APPEND, DONE; remove RSEL, RREAD,
// DONE; failed/unused: DONE; next word taken the cycle after the result loads.
// arst_n empties the list and clears valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_core #(
	parameter int CAPACITY = slri_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] removed_value, [37:32] count, rest zero
	output logic [0:0]       m_tuser    // [0] ok
);

	slri_pkg::dp_cmd_t  cmd;
	slri_pkg::dp_stat_t stat;
	logic                                 out_ok;
	logic signed [slri_pkg::VALUE_W-1:0]  out_removed;
	logic [slri_pkg::COUNT_W-1:0]         out_count;

	slri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_cmd    (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	slri_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.s_value     (s_tdata),
		.out_ok      (out_ok),
		.out_removed (out_removed),
		.out_count   (out_count)
	);

	// output word packing
	assign m_tdata = {2'b00, out_count, out_removed};
	assign m_tuser = out_ok;

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_list_insert_remove_core
// Streams insert, append, remove and unused command words into the core.
// A behavioral copy of the list predicts every result, and each output word
// is compared field by field with the oldest prediction. Traffic runs in
// three idle patterns, with a full drain before each change of pattern.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY = slri_pkg::CAPACITY_DEF;
	localparam logic [slri_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int N_RANDOM  = 1400;
	localparam int TAIL_WAIT = 20;

	typedef struct {
		logic [slri_pkg::CMD_W-1:0]   cmd;
		logic [slri_pkg::VALUE_W-1:0] value;
		int                           phase;
		bit                           drain;
	} list_cmd_t;

	typedef struct {
		logic                         ok;
		logic [slri_pkg::VALUE_W-1:0] removed_value;
		logic [slri_pkg::COUNT_W-1:0] count;
	} list_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	list_cmd_t    pending_cmds[$];
	list_result_t expected_results[$];

	// behavioral copy of the list
	logic [slri_pkg::VALUE_W-1:0] list_entries[CAPACITY];
	int                           list_fill = 0;

	int mismatch_count = 0;
	int sent_cnt       = 0;
	int checked_cnt    = 0;
	int idle_phase     = 0;

	sorted_list_insert_remove_core #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.s_tuser  (s_tuser),   // [1:0] command
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] removed_value, [37:32] count, rest zero
		.m_tuser  (m_tuser)    // [0] ok
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle chance in percent per traffic pattern
	function automatic int idle_pct(input int phase, input bit sender);
		case (phase)
		0: return sender ? 12 : 56;
		1: return sender ? 56 : 12;
		default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s: got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// apply one command to the list copy and queue the result it gives
	task automatic predict_list_op(input logic [slri_pkg::CMD_W-1:0] cmd,
			input logic [slri_pkg::VALUE_W-1:0] val);
		list_result_t r;
		int           pos;
		r.ok            = 1'b0;
		r.removed_value = '0;
		case (cmd)
		slri_pkg::CMD_INSERT, slri_pkg::CMD_APPEND: begin
			if (list_fill < CAPACITY) begin
				pos = list_fill;
				if (cmd == slri_pkg::CMD_INSERT) begin
					// goes before the first greater entry, after equal ones
					pos = 0;
					while (pos < list_fill && $signed(list_entries[pos]) <= $signed(val))
						pos++;
					for (int k = list_fill; k > pos; k--)
						list_entries[k] = list_entries[k-1];
				end
				list_entries[pos] = val;
				list_fill++;
				r.ok = 1'b1;
			end
		end
		slri_pkg::CMD_REMOVE: begin
			if (list_fill > 0) begin
				list_fill--;
				r.removed_value = list_entries[list_fill];
				r.ok            = 1'b1;
			end
		end
		default: ;
		endcase
		r.count = list_fill[slri_pkg::COUNT_W-1:0];
		expected_results.push_back(r);
	endtask

	task automatic add_cmd(input logic [slri_pkg::CMD_W-1:0] cmd,
			input logic [slri_pkg::VALUE_W-1:0] val, input int phase, input bit drain);
		list_cmd_t c;
		c.cmd   = cmd;
		c.value = val;
		c.phase = phase;
		c.drain = drain;
		pending_cmds.push_back(c);
	endtask

	// mix of full-range, small (to get equal values) and extreme values
	function automatic logic [slri_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 9))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2, 3, 4: return $urandom_range(0, 15) - 8;
		default: return $urandom;
		endcase
	endfunction

	// driver: one word held on the slave side until it is taken
	always @(posedge clk) begin : driver
		bit        holding;
		bit        next_valid;
		list_cmd_t c;
		if (arst_n) begin
			holding    = s_tvalid && !s_tready;
			next_valid = holding;
			if (s_tvalid && s_tready) begin
				predict_list_op(s_tuser, s_tdata);
				sent_cnt++;
			end
			if (!holding && pending_cmds.size() > 0) begin
				// a drain mark waits until every result is back
				if (!(pending_cmds[0].drain && sent_cnt != checked_cnt) &&
						$urandom_range(0, 99) >= idle_pct(pending_cmds[0].phase, 1'b1)) begin
					c          = pending_cmds.pop_front();
					next_valid = 1'b1;
					s_tdata    <= c.value;
					s_tuser    <= c.cmd;
					idle_phase <= c.phase;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// monitor: random back-pressure and field checks
	always @(posedge clk) begin : monitor
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with none expected", m_tdata[31:0], '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser[0] !== want.ok)
						report_mismatch("ok", m_tuser[0], want.ok);
					if (m_tdata[31:0] !== want.removed_value)
						report_mismatch("removed_value", m_tdata[31:0], want.removed_value);
					if (m_tdata[37:32] !== want.count)
						report_mismatch("count", m_tdata[37:32], want.count);
					checked_cnt <= checked_cnt + 1;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= idle_pct(idle_phase, 1'b0));
		end
	end

	initial begin : stimulus
		int n;
		int mode;
		int run_len;
		int roll;
		int phase;
		logic [slri_pkg::CMD_W-1:0] cmd;

		// directed: empty list, extremes, equal values, unsorted appends
		add_cmd(slri_pkg::CMD_REMOVE, 32'h1234_5678, 0, 1'b0);
		add_cmd(CMD_UNUSED, 32'hffff_ffff, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h0000_0000, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h7fff_ffff, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h8000_0000, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'hffff_ffff, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h0000_0001, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h0000_0001, 0, 1'b0);
		add_cmd(CMD_UNUSED, 32'h0000_0000, 0, 1'b0);
		add_cmd(slri_pkg::CMD_APPEND, 32'h8000_0001, 0, 1'b0);
		add_cmd(slri_pkg::CMD_APPEND, 32'h0000_0005, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h0000_0002, 0, 1'b0);
		add_cmd(slri_pkg::CMD_INSERT, 32'h7fff_fffe, 0, 1'b0);
		for (int k = 0; k < 11; k++)
			add_cmd(slri_pkg::CMD_REMOVE, 32'hffff_ffff, 0, 1'b0);

		// random: runs that fill, empty, or mix, so full and empty recur
		n = 0;
		phase = 0;
		while (n < N_RANDOM) begin
			mode    = $urandom_range(0, 2);
			run_len = $urandom_range(8, 48);
			for (int k = 0; k < run_len && n < N_RANDOM; k++) begin
				roll = $urandom_range(0, 99);
				case (mode)
				0: cmd = (roll < 60) ? slri_pkg::CMD_INSERT :
						(roll < 80) ? slri_pkg::CMD_APPEND :
						(roll < 96) ? slri_pkg::CMD_REMOVE : CMD_UNUSED;
				1: cmd = (roll < 80) ? slri_pkg::CMD_REMOVE :
						(roll < 90) ? slri_pkg::CMD_INSERT :
						(roll < 96) ? slri_pkg::CMD_APPEND : CMD_UNUSED;
				default: cmd = (roll < 35) ? slri_pkg::CMD_INSERT :
						(roll < 50) ? slri_pkg::CMD_APPEND :
						(roll < 92) ? slri_pkg::CMD_REMOVE : CMD_UNUSED;
				endcase
				add_cmd(cmd, rand_value(), n * 3 / N_RANDOM,
						(n * 3 / N_RANDOM != phase) || ($urandom_range(0, 149) == 0));
				phase = n * 3 / N_RANDOM;
				n++;
			end
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid || sent_cnt != checked_cnt)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results.size(), 0);
		if (mismatch_count == 0) begin
			$display("PASS sorted_list_insert_remove_core");
		end else begin
			$display("FAIL sorted_list_insert_remove_core");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("FAIL sorted_list_insert_remove_core");
		$finish;
	end

endmodule
